// ===== src/cci_pkg.sv =====
// Shared constants for the two-circle intersection block.
// Relation codes, the default coordinate width and the lane count of the point divider.
// No dependencies.
`default_nettype none

package cci_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int REL_W = 3;
    localparam int LANES = 4;

    localparam logic [REL_W-1:0] REL_SEPARATE  = 3'd0;
    localparam logic [REL_W-1:0] REL_CONTAINED = 3'd1;
    localparam logic [REL_W-1:0] REL_IDENTICAL = 3'd2;
    localparam logic [REL_W-1:0] REL_ONE_POINT = 3'd3;
    localparam logic [REL_W-1:0] REL_TWO_POINT = 3'd4;

endpackage

`default_nettype wire

// ===== src/cci_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Carries a sideband vector alongside each radicand. Depends on nothing else.
`default_nettype none

module cci_isqrt #(
    parameter int RW  = 48,
    parameter int SBW = 8
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [2*RW-1:0] radicand,
    input  wire logic [SBW-1:0]  sb_in,
    output logic                 out_valid,
    output logic [RW-1:0]        root,
    output logic [SBW-1:0]       sb_out
);

    logic            vld_reg  [RW];
    logic [2*RW-1:0] rad_reg  [RW];
    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [SBW-1:0]  sb_reg   [RW];

    for (genvar i = 0; i < RW; i++) begin : g_step
        logic            vin;
        logic [2*RW-1:0] rin;
        logic [RW+1:0]   remin;
        logic [RW-1:0]   rootin;
        logic [SBW-1:0]  sbin;
        logic [RW+3:0]   cand;
        logic [RW+3:0]   trial;
        logic            ge;

        if (i == 0) begin : g_first
            assign vin    = in_valid;
            assign rin    = radicand;
            assign remin  = '0;
            assign rootin = '0;
            assign sbin   = sb_in;
        end else begin : g_next
            assign vin    = vld_reg[i-1];
            assign rin    = rad_reg[i-1];
            assign remin  = rem_reg[i-1];
            assign rootin = root_reg[i-1];
            assign sbin   = sb_reg[i-1];
        end

        assign cand  = {remin, rin[2*RW-1 -: 2]};
        assign trial = (RW+4)'({rootin, 2'b01});
        assign ge    = cand >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[i]  <= rin << 2;
                rem_reg[i]  <= ge ? (RW+2)'(cand - trial) : (RW+2)'(cand);
                root_reg[i] <= {rootin[RW-2:0], ge};
                sb_reg[i]   <= sbin;
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign sb_out    = sb_reg[RW-1];

endmodule

`default_nettype wire

// ===== src/cci_div.sv =====
// Pipelined restoring divider for the four point lanes: an overflow check stage, then one quotient bit per stage.
// All lanes share one divisor; a lane flags overflow when its quotient needs more bits.
// Depends on cci_pkg.
`default_nettype none

module cci_div
    import cci_pkg::*;
#(
    parameter int NW   = 76,
    parameter int DENW = 49,
    parameter int QW   = 25,
    parameter int SBW  = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [LANES-1:0][NW-1:0]   num,
    input  wire logic [DENW-1:0]            den,
    input  wire logic [SBW-1:0]             sb_in,
    output logic                            out_valid,
    output logic [LANES-1:0][QW-1:0]        quo,
    output logic [LANES-1:0]                ovf,
    output logic [SBW-1:0]                  sb_out
);

    logic                     vld_reg [QW+1];
    logic [LANES-1:0][NW-1:0] rem_reg [QW+1];
    logic [LANES-1:0][QW-1:0] q_reg   [QW+1];
    logic [LANES-1:0]         ovf_reg [QW+1];
    logic [DENW-1:0]          den_reg [QW+1];
    logic [SBW-1:0]           sb_reg  [QW+1];
    logic [LANES-1:0]         ovf_next;

    for (genvar l = 0; l < LANES; l++) begin : g_ovf
        assign ovf_next[l] = num[l] >= (NW'(den) << QW);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf_next;
            den_reg[0] <= den;
            sb_reg[0]  <= sb_in;
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_step
        logic [NW-1:0]            dsh;
        logic [LANES-1:0][NW-1:0] rem_next;
        logic [LANES-1:0][QW-1:0] q_next;

        assign dsh = NW'(den_reg[j-1]) << (QW - j);

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic ge;
            assign ge          = rem_reg[j-1][l] >= dsh;
            assign rem_next[l] = ge ? rem_reg[j-1][l] - dsh : rem_reg[j-1][l];
            assign q_next[l]   = {q_reg[j-1][l][QW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= rem_next;
                q_reg[j]   <= q_next;
                ovf_reg[j] <= ovf_reg[j-1];
                den_reg[j] <= den_reg[j-1];
                sb_reg[j]  <= sb_reg[j-1];
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign quo       = q_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign sb_out    = sb_reg[QW];

endmodule

`default_nettype wire

// ===== src/circle_circle_intersection.sv =====
// Two-circle intersection: classification and intersection points, fully pipelined.
// Depends on cci_pkg, cci_isqrt and cci_div.
//
// Usage: the input channel (s_valid/s_ready) takes two circles, centers in two's
// complement and radii unsigned, all with the same binary point. The result channel
// (m_valid/m_ready) gives the relation code and up to two points, saturated to the
// coordinate range, in input order. Non-meeting circles return zero points; a
// touching pair returns its point in A and zeros in B.
// Throughput: one transaction per cycle while s_ready is high. The datapath holds the square
// root pipeline (2*COORD_WIDTH stages, one root bit each) and the point divider
// (COORD_WIDTH+2 stages: an overflow check, then one quotient bit each), plus the
// multiply and add stages.
// Reset clears every valid bit; the block takes a transaction in the first cycle after.
// When the receiver stalls, the result waits in the output register and one more
// result moves into a skid register; only then does s_ready fall and the whole
// pipeline hold its contents until the output drains.
`default_nettype none

module circle_circle_intersection
    import cci_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [COORD_WIDTH-1:0] s_first_center_x,
    input  wire logic [COORD_WIDTH-1:0] s_first_center_y,
    input  wire logic [COORD_WIDTH-2:0] s_first_radius,
    input  wire logic [COORD_WIDTH-1:0] s_second_center_x,
    input  wire logic [COORD_WIDTH-1:0] s_second_center_y,
    input  wire logic [COORD_WIDTH-2:0] s_second_radius,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [REL_W-1:0]            m_relation,
    output logic [COORD_WIDTH-1:0]      m_point_a_x,
    output logic [COORD_WIDTH-1:0]      m_point_a_y,
    output logic [COORD_WIDTH-1:0]      m_point_b_x,
    output logic [COORD_WIDTH-1:0]      m_point_b_y
);

    localparam int W    = COORD_WIDTH;
    localparam int AW   = W + 1;
    localparam int RQW  = W - 1;
    localparam int D2FW = 2 * W + 2;
    localparam int DW   = 2 * W;
    localparam int KW   = 2 * W + 1;
    localparam int MW   = 4 * W;
    localparam int SW   = 2 * W;
    localparam int TW   = 3 * W + 2;
    localparam int MGW  = TW + 1;
    localparam int NW   = TW + 2;
    localparam int DENW = DW + 1;
    localparam int QW   = W + 1;
    localparam int PW   = W + 3;
    localparam int SQSB = 2 * W + 2 * AW + 2 + REL_W + DW + KW + 1;
    localparam int DVSB = 2 * W + REL_W + 1 + LANES;
    localparam int OUTW = REL_W + 4 * W;

    localparam logic [PW-1:0] HI_C = PW'((64'd1 << (W - 1)) - 64'd1);
    localparam logic [PW-1:0] LO_C = ~HI_C;

    function automatic logic [MGW:0] lane_mag(input logic n1, input logic [TW-1:0] m1,
                                              input logic n2, input logic [TW-1:0] m2);
        logic [MGW-1:0] sum;
        logic [MGW-1:0] d12;
        logic [MGW-1:0] d21;
        sum = MGW'(m1) + MGW'(m2);
        d12 = MGW'(m1) - MGW'(m2);
        d21 = MGW'(m2) - MGW'(m1);
        if (n1 == n2) begin
            return {n1, sum};
        end else if (!d12[MGW-1]) begin
            return {n1, d12};
        end else begin
            return {n2, d21};
        end
    endfunction

    function automatic logic [W-1:0] place(input logic [W-1:0] c, input logic neg,
                                           input logic ovf, input logic [QW-1:0] q);
        logic [PW-1:0] v;
        v = neg ? {{3{c[W-1]}}, c} - PW'(q) : {{3{c[W-1]}}, c} + PW'(q);
        if (ovf) begin
            return neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else if ($signed(v) > $signed(HI_C)) begin
            return HI_C[W-1:0];
        end else if ($signed(v) < $signed(LO_C)) begin
            return LO_C[W-1:0];
        end else begin
            return v[W-1:0];
        end
    endfunction

    logic en;
    logic out_valid_reg, skid_valid_reg;
    logic [OUTW-1:0] out_data_reg, skid_data_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // Stage 1: center differences and radius sum and difference.
    logic [AW-1:0] dx_c, dy_c;
    logic s1_valid_reg;
    logic [W-1:0] s1_x1_reg, s1_y1_reg, s1_rsum_reg;
    logic [AW-1:0] s1_adx_reg, s1_ady_reg;
    logic s1_dxn_reg, s1_dyn_reg, s1_req_reg;
    logic [RQW-1:0] s1_r1_reg, s1_r2_reg, s1_rdif_reg;

    assign dx_c = {s_second_center_x[W-1], s_second_center_x}
                - {s_first_center_x[W-1], s_first_center_x};
    assign dy_c = {s_second_center_y[W-1], s_second_center_y}
                - {s_first_center_y[W-1], s_first_center_y};

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_x1_reg   <= s_first_center_x;
            s1_y1_reg   <= s_first_center_y;
            s1_adx_reg  <= dx_c[AW-1] ? ~dx_c + AW'(1) : dx_c;
            s1_ady_reg  <= dy_c[AW-1] ? ~dy_c + AW'(1) : dy_c;
            s1_dxn_reg  <= dx_c[AW-1];
            s1_dyn_reg  <= dy_c[AW-1];
            s1_r1_reg   <= s_first_radius;
            s1_r2_reg   <= s_second_radius;
            s1_rsum_reg <= {1'b0, s_first_radius} + {1'b0, s_second_radius};
            s1_rdif_reg <= (s_first_radius > s_second_radius) ?
                           s_first_radius - s_second_radius :
                           s_second_radius - s_first_radius;
            s1_req_reg  <= s_first_radius == s_second_radius;
        end
    end

    // Stage 2: squares.
    logic s2_valid_reg;
    logic [W-1:0] s2_x1_reg, s2_y1_reg;
    logic [AW-1:0] s2_adx_reg, s2_ady_reg;
    logic s2_dxn_reg, s2_dyn_reg, s2_req_reg;
    logic [2*AW-1:0] s2_adx2_reg, s2_ady2_reg;
    logic [2*RQW-1:0] s2_r1sq_reg, s2_r2sq_reg, s2_difsq_reg;
    logic [DW-1:0] s2_sumsq_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_x1_reg    <= s1_x1_reg;
            s2_y1_reg    <= s1_y1_reg;
            s2_adx_reg   <= s1_adx_reg;
            s2_ady_reg   <= s1_ady_reg;
            s2_dxn_reg   <= s1_dxn_reg;
            s2_dyn_reg   <= s1_dyn_reg;
            s2_req_reg   <= s1_req_reg;
            s2_adx2_reg  <= (2*AW)'(s1_adx_reg) * (2*AW)'(s1_adx_reg);
            s2_ady2_reg  <= (2*AW)'(s1_ady_reg) * (2*AW)'(s1_ady_reg);
            s2_r1sq_reg  <= (2*RQW)'(s1_r1_reg) * (2*RQW)'(s1_r1_reg);
            s2_r2sq_reg  <= (2*RQW)'(s1_r2_reg) * (2*RQW)'(s1_r2_reg);
            s2_difsq_reg <= (2*RQW)'(s1_rdif_reg) * (2*RQW)'(s1_rdif_reg);
            s2_sumsq_reg <= DW'(s1_rsum_reg) * DW'(s1_rsum_reg);
        end
    end

    // Stage 3: squared center distance.
    logic s3_valid_reg;
    logic [W-1:0] s3_x1_reg, s3_y1_reg;
    logic [AW-1:0] s3_adx_reg, s3_ady_reg;
    logic s3_dxn_reg, s3_dyn_reg, s3_req_reg;
    logic [D2FW-1:0] s3_d2f_reg;
    logic [2*RQW-1:0] s3_r1sq_reg, s3_r2sq_reg, s3_difsq_reg;
    logic [DW-1:0] s3_sumsq_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_x1_reg    <= s2_x1_reg;
            s3_y1_reg    <= s2_y1_reg;
            s3_adx_reg   <= s2_adx_reg;
            s3_ady_reg   <= s2_ady_reg;
            s3_dxn_reg   <= s2_dxn_reg;
            s3_dyn_reg   <= s2_dyn_reg;
            s3_req_reg   <= s2_req_reg;
            s3_d2f_reg   <= s2_adx2_reg + s2_ady2_reg;
            s3_r1sq_reg  <= s2_r1sq_reg;
            s3_r2sq_reg  <= s2_r2sq_reg;
            s3_difsq_reg <= s2_difsq_reg;
            s3_sumsq_reg <= s2_sumsq_reg;
        end
    end

    // Stage 4: classification and the two radicand factors.
    logic [REL_W-1:0] rel_next;
    logic [DW-1:0] d2_c;
    logic s4_valid_reg;
    logic [W-1:0] s4_x1_reg, s4_y1_reg;
    logic [AW-1:0] s4_adx_reg, s4_ady_reg;
    logic s4_dxn_reg, s4_dyn_reg;
    logic [REL_W-1:0] s4_rel_reg;
    logic [DW-1:0] s4_d2_reg, s4_ma_reg, s4_mb_reg;
    logic [DW:0] s4_kpos_reg;
    logic [2*RQW-1:0] s4_r2sq_reg;

    assign d2_c = s3_d2f_reg[DW-1:0];

    always_comb begin
        if (s3_d2f_reg > D2FW'(s3_sumsq_reg)) begin
            rel_next = REL_SEPARATE;
        end else if (s3_d2f_reg < D2FW'(s3_difsq_reg)) begin
            rel_next = REL_CONTAINED;
        end else if (s3_d2f_reg == '0 && s3_req_reg) begin
            rel_next = REL_IDENTICAL;
        end else begin
            rel_next = REL_TWO_POINT;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_x1_reg   <= s3_x1_reg;
            s4_y1_reg   <= s3_y1_reg;
            s4_adx_reg  <= s3_adx_reg;
            s4_ady_reg  <= s3_ady_reg;
            s4_dxn_reg  <= s3_dxn_reg;
            s4_dyn_reg  <= s3_dyn_reg;
            s4_rel_reg  <= rel_next;
            s4_d2_reg   <= d2_c;
            s4_kpos_reg <= (DW+1)'(s3_r1sq_reg) + (DW+1)'(d2_c);
            s4_r2sq_reg <= s3_r2sq_reg;
            s4_ma_reg   <= d2_c - DW'(s3_difsq_reg);
            s4_mb_reg   <= s3_sumsq_reg - d2_c;
        end
    end

    // Stage 5: chord term K and partial products of the radicand.
    logic kge_c;
    logic s5_valid_reg;
    logic [W-1:0] s5_x1_reg, s5_y1_reg;
    logic [AW-1:0] s5_adx_reg, s5_ady_reg;
    logic s5_dxn_reg, s5_dyn_reg, s5_kneg_reg;
    logic [REL_W-1:0] s5_rel_reg;
    logic [DW-1:0] s5_d2_reg, s5_pll_reg, s5_plh_reg, s5_phl_reg, s5_phh_reg;
    logic [KW-1:0] s5_kmag_reg;

    assign kge_c = s4_kpos_reg >= (DW+1)'(s4_r2sq_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_x1_reg   <= s4_x1_reg;
            s5_y1_reg   <= s4_y1_reg;
            s5_adx_reg  <= s4_adx_reg;
            s5_ady_reg  <= s4_ady_reg;
            s5_dxn_reg  <= s4_dxn_reg;
            s5_dyn_reg  <= s4_dyn_reg;
            s5_rel_reg  <= s4_rel_reg;
            s5_d2_reg   <= s4_d2_reg;
            s5_kneg_reg <= !kge_c;
            s5_kmag_reg <= kge_c ? s4_kpos_reg - (DW+1)'(s4_r2sq_reg)
                                 : (DW+1)'(s4_r2sq_reg) - s4_kpos_reg;
            s5_pll_reg  <= DW'(s4_ma_reg[W-1:0]) * DW'(s4_mb_reg[W-1:0]);
            s5_plh_reg  <= DW'(s4_ma_reg[W-1:0]) * DW'(s4_mb_reg[DW-1:W]);
            s5_phl_reg  <= DW'(s4_ma_reg[DW-1:W]) * DW'(s4_mb_reg[W-1:0]);
            s5_phh_reg  <= DW'(s4_ma_reg[DW-1:W]) * DW'(s4_mb_reg[DW-1:W]);
        end
    end

    // Stage 6: radicand assembly.
    logic s6_valid_reg;
    logic [MW-1:0] s6_m_reg;
    logic [SQSB-1:0] s6_sb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s6_m_reg  <= {s5_phh_reg, s5_pll_reg}
                       + (MW'((DW+1)'(s5_plh_reg) + (DW+1)'(s5_phl_reg)) << W);
            s6_sb_reg <= {s5_x1_reg, s5_y1_reg, s5_adx_reg, s5_ady_reg, s5_dxn_reg,
                          s5_dyn_reg, s5_rel_reg, s5_d2_reg, s5_kmag_reg, s5_kneg_reg};
        end
    end

    logic sq_valid;
    logic [SW-1:0] sq_root;
    logic [SQSB-1:0] sq_sb;
    logic [W-1:0] u_x1, u_y1;
    logic [AW-1:0] u_adx, u_ady;
    logic u_dxn, u_dyn, u_kneg;
    logic [REL_W-1:0] u_rel;
    logic [DW-1:0] u_d2;
    logic [KW-1:0] u_kmag;

    cci_isqrt #(
        .RW (SW),
        .SBW(SQSB)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s6_valid_reg),
        .radicand (s6_m_reg),
        .sb_in    (s6_sb_reg),
        .out_valid(sq_valid),
        .root     (sq_root),
        .sb_out   (sq_sb)
    );

    assign {u_x1, u_y1, u_adx, u_ady, u_dxn, u_dyn, u_rel, u_d2, u_kmag, u_kneg} = sq_sb;

    // Stage 7: partial products of K and S with the center offsets.
    logic p1_valid_reg;
    logic [W-1:0] p1_x1_reg, p1_y1_reg;
    logic p1_dxn_reg, p1_dyn_reg, p1_kneg_reg, p1_szero_reg;
    logic [REL_W-1:0] p1_rel_reg;
    logic [DW-1:0] p1_d2_reg;
    logic [2*AW-1:0] p1_pkhx_reg, p1_pkhy_reg;
    logic [W+AW-1:0] p1_pklx_reg, p1_pkly_reg;
    logic [W+AW-1:0] p1_pshx_reg, p1_pslx_reg, p1_pshy_reg, p1_psly_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_x1_reg    <= u_x1;
            p1_y1_reg    <= u_y1;
            p1_dxn_reg   <= u_dxn;
            p1_dyn_reg   <= u_dyn;
            p1_kneg_reg  <= u_kneg;
            p1_szero_reg <= sq_root == '0;
            p1_rel_reg   <= u_rel;
            p1_d2_reg    <= u_d2;
            p1_pkhx_reg  <= (2*AW)'(u_kmag[KW-1:W]) * (2*AW)'(u_adx);
            p1_pkhy_reg  <= (2*AW)'(u_kmag[KW-1:W]) * (2*AW)'(u_ady);
            p1_pklx_reg  <= (W+AW)'(u_kmag[W-1:0]) * (W+AW)'(u_adx);
            p1_pkly_reg  <= (W+AW)'(u_kmag[W-1:0]) * (W+AW)'(u_ady);
            p1_pshx_reg  <= (W+AW)'(sq_root[SW-1:W]) * (W+AW)'(u_adx);
            p1_pslx_reg  <= (W+AW)'(sq_root[W-1:0]) * (W+AW)'(u_adx);
            p1_pshy_reg  <= (W+AW)'(sq_root[SW-1:W]) * (W+AW)'(u_ady);
            p1_psly_reg  <= (W+AW)'(sq_root[W-1:0]) * (W+AW)'(u_ady);
        end
    end

    // Stage 8: full products.
    logic p2_valid_reg;
    logic [W-1:0] p2_x1_reg, p2_y1_reg;
    logic p2_dxn_reg, p2_dyn_reg, p2_kneg_reg, p2_szero_reg;
    logic [REL_W-1:0] p2_rel_reg;
    logic [DW-1:0] p2_d2_reg;
    logic [TW-1:0] p2_tkx_reg, p2_tky_reg, p2_tsx_reg, p2_tsy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_x1_reg    <= p1_x1_reg;
            p2_y1_reg    <= p1_y1_reg;
            p2_dxn_reg   <= p1_dxn_reg;
            p2_dyn_reg   <= p1_dyn_reg;
            p2_kneg_reg  <= p1_kneg_reg;
            p2_szero_reg <= p1_szero_reg;
            p2_rel_reg   <= p1_rel_reg;
            p2_d2_reg    <= p1_d2_reg;
            p2_tkx_reg   <= (TW'(p1_pkhx_reg) << W) + TW'(p1_pklx_reg);
            p2_tky_reg   <= (TW'(p1_pkhy_reg) << W) + TW'(p1_pkly_reg);
            p2_tsx_reg   <= (TW'(p1_pshx_reg) << W) + TW'(p1_pslx_reg);
            p2_tsy_reg   <= (TW'(p1_pshy_reg) << W) + TW'(p1_psly_reg);
        end
    end

    // Stage 9: signed combination of the chord and height terms per coordinate.
    logic [LANES-1:0][MGW:0] lane_c;
    logic p3_valid_reg;
    logic [W-1:0] p3_x1_reg, p3_y1_reg;
    logic p3_szero_reg;
    logic [REL_W-1:0] p3_rel_reg;
    logic [DW-1:0] p3_d2_reg;
    logic [LANES-1:0][MGW-1:0] p3_mag_reg;
    logic [LANES-1:0] p3_neg_reg;

    assign lane_c[0] = lane_mag(p2_kneg_reg ^ p2_dxn_reg, p2_tkx_reg, p2_dyn_reg, p2_tsy_reg);
    assign lane_c[1] = lane_mag(p2_kneg_reg ^ p2_dyn_reg, p2_tky_reg, !p2_dxn_reg, p2_tsx_reg);
    assign lane_c[2] = lane_mag(p2_kneg_reg ^ p2_dxn_reg, p2_tkx_reg, !p2_dyn_reg, p2_tsy_reg);
    assign lane_c[3] = lane_mag(p2_kneg_reg ^ p2_dyn_reg, p2_tky_reg, p2_dxn_reg, p2_tsx_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_x1_reg    <= p2_x1_reg;
            p3_y1_reg    <= p2_y1_reg;
            p3_szero_reg <= p2_szero_reg;
            p3_rel_reg   <= p2_rel_reg;
            p3_d2_reg    <= p2_d2_reg;
            for (int l = 0; l < LANES; l++) begin
                p3_neg_reg[l] <= lane_c[l][MGW];
                p3_mag_reg[l] <= lane_c[l][MGW-1:0];
            end
        end
    end

    // Stage 10: rounding offset and divisor.
    logic p4_valid_reg;
    logic [LANES-1:0][NW-1:0] p4_num_reg;
    logic [DENW-1:0] p4_den_reg;
    logic [DVSB-1:0] p4_sb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                p4_num_reg[l] <= NW'(p3_mag_reg[l]) + NW'(p3_d2_reg);
            end
            p4_den_reg <= {p3_d2_reg, 1'b0};
            p4_sb_reg  <= {p3_x1_reg, p3_y1_reg, p3_rel_reg, p3_szero_reg, p3_neg_reg};
        end
    end

    logic dv_valid;
    logic [LANES-1:0][QW-1:0] dv_quo;
    logic [LANES-1:0] dv_ovf;
    logic [DVSB-1:0] dv_sb;
    logic [W-1:0] v_x1, v_y1;
    logic [REL_W-1:0] v_rel;
    logic v_szero;
    logic [LANES-1:0] v_neg;

    cci_div #(
        .NW  (NW),
        .DENW(DENW),
        .QW  (QW),
        .SBW (DVSB)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (p4_valid_reg),
        .num      (p4_num_reg),
        .den      (p4_den_reg),
        .sb_in    (p4_sb_reg),
        .out_valid(dv_valid),
        .quo      (dv_quo),
        .ovf      (dv_ovf),
        .sb_out   (dv_sb)
    );

    assign {v_x1, v_y1, v_rel, v_szero, v_neg} = dv_sb;

    // Final stage: placement, saturation and the relation code.
    logic [LANES-1:0][W-1:0] pt_c;
    logic [OUTW-1:0] fin_next;
    logic fin_valid_reg;
    logic [OUTW-1:0] fin_data_reg;

    for (genvar l = 0; l < LANES; l++) begin : g_place
        assign pt_c[l] = place((l % 2 == 0) ? v_x1 : v_y1, v_neg[l], dv_ovf[l], dv_quo[l]);
    end

    always_comb begin
        if (v_rel != REL_TWO_POINT) begin
            fin_next = {v_rel, {(4*W){1'b0}}};
        end else if (v_szero) begin
            fin_next = {REL_ONE_POINT, pt_c[0], pt_c[1], {(2*W){1'b0}}};
        end else begin
            fin_next = {REL_TWO_POINT, pt_c[0], pt_c[1], pt_c[2], pt_c[3]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_data_reg <= fin_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg  <= s_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            p1_valid_reg  <= sq_valid;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            fin_valid_reg <= dv_valid;
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= fin_valid_reg;
            end
        end else if (fin_valid_reg && en) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : fin_data_reg;
        end else if (en) begin
            skid_data_reg <= fin_data_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign {m_relation, m_point_a_x, m_point_a_y, m_point_b_x, m_point_b_y} = out_data_reg;

    a_skid_needs_output : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    a_skid_fill_on_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid register filled without a stalled output");

    a_relation_code : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_relation <= REL_TWO_POINT)
        else $error("relation code out of range");

    a_no_points_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_relation == REL_SEPARATE || m_relation == REL_CONTAINED ||
                    m_relation == REL_IDENTICAL)
        |-> (m_point_a_x == '0 && m_point_a_y == '0 &&
             m_point_b_x == '0 && m_point_b_y == '0))
        else $error("points reported for circles that do not meet");

    a_one_point_b_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_relation == REL_ONE_POINT |-> (m_point_b_x == '0 && m_point_b_y == '0))
        else $error("second point reported for touching circles");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for circle_circle_intersection: directed and random circle pairs.
// A scoreboard class predicts the relation and points from exact integer arithmetic.
// Depends on cci_pkg and the RTL of the block.

typedef struct packed {
    logic [2:0]  relation;
    logic [23:0] a_x;
    logic [23:0] a_y;
    logic [23:0] b_x;
    logic [23:0] b_y;
} cci_result_t;

class cci_scoreboard;
    cci_result_t expected_q[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    function logic [127:0] isqrt(logic [127:0] n);
        logic [127:0] res;
        logic [127:0] bitv;
        res  = 0;
        bitv = 128'd1 << 126;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function logic [23:0] place(longint c, bit n1, logic [127:0] m1, bit n2,
                                logic [127:0] m2, logic [127:0] d2);
        bit           neg;
        logic [127:0] mag;
        logic [127:0] q;
        longint       v;
        if (n1 == n2) begin
            neg = n1;
            mag = m1 + m2;
        end else if (m1 >= m2) begin
            neg = n1;
            mag = m1 - m2;
        end else begin
            neg = n2;
            mag = m2 - m1;
        end
        q = (mag + d2) / (d2 << 1);
        if (q > (128'd1 << 40)) q = 128'd1 << 40;
        v = neg ? c - longint'(q[63:0]) : c + longint'(q[63:0]);
        if (v > 64'sd8388607) v = 64'sd8388607;
        if (v < -64'sd8388608) v = -64'sd8388608;
        return v[23:0];
    endfunction

    function void note_transaction(logic [23:0] fx, logic [23:0] fy, logic [22:0] fr,
                                   logic [23:0] sx, logic [23:0] sy, logic [22:0] sr);
        cci_result_t  res;
        longint       x1, y1, x2, y2, dx, dy;
        logic [127:0] adx, ady, r1, r2, d2, rsum, rdif, sumsq, difsq;
        logic [127:0] pos, negp, kmag, m, s, tkx, tky, tsx, tsy;
        bit           kneg;
        x1 = longint'(signed'(fx));
        y1 = longint'(signed'(fy));
        x2 = longint'(signed'(sx));
        y2 = longint'(signed'(sy));
        r1 = fr;
        r2 = sr;
        dx = x2 - x1;
        dy = y2 - y1;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        d2 = adx * adx + ady * ady;
        rsum = r1 + r2;
        rdif = (r1 > r2) ? r1 - r2 : r2 - r1;
        sumsq = rsum * rsum;
        difsq = rdif * rdif;
        res = '0;
        if (d2 > sumsq) begin
            res.relation = cci_pkg::REL_SEPARATE;
        end else if (d2 < difsq) begin
            res.relation = cci_pkg::REL_CONTAINED;
        end else if (d2 == 0 && r1 == r2) begin
            res.relation = cci_pkg::REL_IDENTICAL;
        end else begin
            pos  = r1 * r1 + d2;
            negp = r2 * r2;
            kneg = pos < negp;
            kmag = kneg ? negp - pos : pos - negp;
            m    = (d2 - difsq) * (sumsq - d2);
            s    = isqrt(m);
            tkx  = kmag * adx;
            tky  = kmag * ady;
            tsx  = s * adx;
            tsy  = s * ady;
            res.a_x = place(x1, kneg != (dx < 0), tkx, dy < 0, tsy, d2);
            res.a_y = place(y1, kneg != (dy < 0), tky, !(dx < 0), tsx, d2);
            if (s == 0) begin
                res.relation = cci_pkg::REL_ONE_POINT;
            end else begin
                res.relation = cci_pkg::REL_TWO_POINT;
                res.b_x = place(x1, kneg != (dx < 0), tkx, !(dy < 0), tsy, d2);
                res.b_y = place(y1, kneg != (dy < 0), tky, dx < 0, tsx, d2);
            end
        end
        expected_q.push_back(res);
    endfunction

    function void check_result(cci_result_t got);
        cci_result_t exp_r;
        if (expected_q.size() == 0) begin
            $error("result with no transaction outstanding");
            errors++;
            return;
        end
        exp_r = expected_q.pop_front();
        if (got.relation !== exp_r.relation) begin
            $error("relation: expected %0d, got %0d", exp_r.relation, got.relation);
            errors++;
        end
        if (got.a_x !== exp_r.a_x) begin
            $error("point_a_x: expected %h, got %h", exp_r.a_x, got.a_x);
            errors++;
        end
        if (got.a_y !== exp_r.a_y) begin
            $error("point_a_y: expected %h, got %h", exp_r.a_y, got.a_y);
            errors++;
        end
        if (got.b_x !== exp_r.b_x) begin
            $error("point_b_x: expected %h, got %h", exp_r.b_x, got.b_x);
            errors++;
        end
        if (got.b_y !== exp_r.b_y) begin
            $error("point_b_y: expected %h, got %h", exp_r.b_y, got.b_y);
            errors++;
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1250;
    localparam int IDLE_LIMIT = 5000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [23:0] s_first_center_x;
    logic [23:0] s_first_center_y;
    logic [22:0] s_first_radius;
    logic [23:0] s_second_center_x;
    logic [23:0] s_second_center_y;
    logic [22:0] s_second_radius;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_relation;
    logic [23:0] m_point_a_x;
    logic [23:0] m_point_a_y;
    logic [23:0] m_point_b_x;
    logic [23:0] m_point_b_y;

    cci_scoreboard sb = new();
    int  sent_count = 0;
    int  idle_cycles = 0;
    bit  holdoff_req = 0;

    circle_circle_intersection u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_first_center_x  (s_first_center_x),
        .s_first_center_y  (s_first_center_y),
        .s_first_radius    (s_first_radius),
        .s_second_center_x (s_second_center_x),
        .s_second_center_y (s_second_center_y),
        .s_second_radius   (s_second_radius),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_relation        (m_relation),
        .m_point_a_x       (m_point_a_x),
        .m_point_a_y       (m_point_a_y),
        .m_point_b_x       (m_point_b_x),
        .m_point_b_y       (m_point_b_y)
    );

    initial aclk = 0;
    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    task send_circles(logic [23:0] fx, logic [23:0] fy, logic [22:0] fr,
                      logic [23:0] sx, logic [23:0] sy, logic [22:0] sr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_first_center_x  <= fx;
        s_first_center_y  <= fy;
        s_first_radius    <= fr;
        s_second_center_x <= sx;
        s_second_center_y <= sy;
        s_second_radius   <= sr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
    endtask

    task send_random_pair();
        logic [23:0] fx, fy, sx, sy;
        logic [22:0] fr, sr;
        longint      span, dx, dy;
        int          k, mode;
        mode = $urandom_range(0, 9);
        k  = $urandom_range(2, 22);
        fx = 24'($urandom);
        fy = 24'($urandom);
        fr = 23'($urandom & ((32'd1 << k) - 32'd1));
        sr = 23'($urandom & ((32'd1 << k) - 32'd1));
        span = longint'(fr) + longint'(sr) + 1;
        if (mode < 2) begin
            sx = 24'($urandom);
            sy = 24'($urandom);
            fr = 23'($urandom);
            sr = 23'($urandom);
        end else if (mode == 2) begin
            // Tangent pairs along an axis, outside or inside.
            dx = $urandom_range(0, 1) ? longint'(fr) + longint'(sr)
                                      : longint'(fr) - longint'(sr);
            sx = fx + dx[23:0];
            sy = fy;
        end else begin
            dx = longint'($urandom_range(0, 32'(2 * span))) - span;
            dy = longint'($urandom_range(0, 32'(2 * span))) - span;
            sx = fx + dx[23:0];
            sy = fy + dy[23:0];
        end
        send_circles(fx, fy, fr, sx, sy, sr);
    endtask

    initial begin
        aresetn           <= 1'b0;
        s_valid           <= 1'b0;
        s_first_center_x  <= '0;
        s_first_center_y  <= '0;
        s_first_radius    <= '0;
        s_second_center_x <= '0;
        s_second_center_y <= '0;
        s_second_radius   <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_circles(24'd0, 24'd0, 23'd256, 24'd5000, 24'd0, 23'd256);
        send_circles(24'd0, 24'd0, 23'd2560, 24'd100, 24'd50, 23'd256);
        send_circles(24'd300, -24'd300, 23'd777, 24'd300, -24'd300, 23'd777);
        send_circles(24'd0, 24'd0, 23'd0, 24'd0, 24'd0, 23'd0);
        send_circles(24'd0, 24'd0, 23'd256, 24'd512, 24'd0, 23'd256);
        send_circles(24'd0, 24'd0, 23'd512, 24'd256, 24'd0, 23'd256);
        send_circles(24'd0, 24'd0, 23'd1280, 24'd0, 24'd1536, 23'd1280);
        send_circles(24'd100, 24'd200, 23'd1000, -24'd700, 24'd900, 23'd900);
        send_circles(24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 24'h800000, 24'h800000,
                     23'h7FFFFF);
        send_circles(24'h7FFFF0, 24'h7FFFF0, 23'h400000, 24'h7FFFF0, 24'h3FFFF0,
                     23'h400000);
        send_circles(24'h800010, 24'h800010, 23'h400000, 24'h800010, 24'hC00010,
                     23'h400000);
        send_circles(24'h800000, 24'd0, 23'h7FFFFF, 24'h7FFFFF, 24'd0, 23'h7FFFFF);
        send_circles(24'd0, 24'd0, 23'h7FFFFF, 24'd0, 24'd0, 23'd0);
        send_circles(24'd0, 24'd0, 23'd5, 24'd3, 24'd4, 23'd0);
        send_circles(24'd0, 24'd0, 23'd0, 24'd1, 24'd0, 23'd1);
        send_circles(24'd0, 24'd0, 23'd1, 24'd1, 24'd1, 23'd1);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 400) holdoff_req = 1'b1;
            if (i == 800) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (sb.expected_q.size() != 0) @(posedge aclk);
            end
            send_random_pair();
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (holdoff_req) begin
                holdoff_req = 1'b0;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_transaction(s_first_center_x, s_first_center_y, s_first_radius,
                                    s_second_center_x, s_second_center_y,
                                    s_second_radius);
            end
            if (m_valid && m_ready) begin
                sb.check_result('{m_relation, m_point_a_x, m_point_a_y,
                                  m_point_b_x, m_point_b_y});
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end
endmodule

// ===== files.f =====
src/cci_pkg.sv
src/cci_isqrt.sv
src/cci_div.sv
src/circle_circle_intersection.sv
sim/tb_top.sv
